>>> rtl/core/ppa_pkg.sv
// Shared types, constants and helper functions for the path point absolutizer.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package ppa_pkg;

    // Internal coordinate width; sums saturate to this signed range
    localparam int COORD_WIDTH = 32;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // Path letters (ASCII)
    localparam logic [7:0] LTR_UC_M = 8'h4D;
    localparam logic [7:0] LTR_UC_L = 8'h4C;
    localparam logic [7:0] LTR_UC_C = 8'h43;
    localparam logic [7:0] LTR_UC_S = 8'h53;
    localparam logic [7:0] LTR_UC_Q = 8'h51;
    localparam logic [7:0] LTR_UC_T = 8'h54;
    localparam logic [7:0] LTR_LC_M = 8'h6D;
    localparam logic [7:0] LTR_LC_L = 8'h6C;
    localparam logic [7:0] LTR_LC_C = 8'h63;
    localparam logic [7:0] LTR_LC_S = 8'h73;
    localparam logic [7:0] LTR_LC_Q = 8'h71;
    localparam logic [7:0] LTR_LC_T = 8'h74;
    localparam logic [7:0] LTR_UC_H = 8'h48;
    localparam logic [7:0] LTR_LC_H = 8'h68;
    localparam logic [7:0] LTR_UC_V = 8'h56;
    localparam logic [7:0] LTR_LC_V = 8'h76;
    localparam logic [7:0] LTR_UC_A = 8'h41;
    localparam logic [7:0] LTR_LC_A = 8'h61;

    // Token kinds
    localparam logic CMD_LETTER = 1'b0;
    localparam logic CMD_PARAM  = 1'b1;

    // Parameter positions within a pair or an arc group
    localparam logic [2:0] POS_START = 3'd0;
    localparam logic [2:0] POS_PAIR_Y = 3'd1;
    localparam logic [2:0] POS_ARC_X = 3'd5;
    localparam logic [2:0] POS_ARC_Y = 3'd6;

    typedef enum logic [3:0] {
        CLS_NONE,
        CLS_PAIR_ABS,
        CLS_PAIR_REL,
        CLS_H_ABS,
        CLS_H_REL,
        CLS_V_ABS,
        CLS_V_REL,
        CLS_ARC_ABS,
        CLS_ARC_REL
    } letter_class_t;

    typedef struct packed {
        logic               command;
        logic [7:0]         path_letter;
        logic signed [31:0] value;
    } ppa_in_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } ppa_out_t;

    // Input register contents handed to the point unit
    typedef struct packed {
        logic    valid;
        ppa_in_t data;
    } ppa_slot_t;

    // Outcome of one token from the point unit
    typedef struct packed {
        logic     emit;
        ppa_out_t point;
    } ppa_step_t;

    function automatic letter_class_t letter_class(input logic [7:0] ltr);
        letter_class_t cls;
        cls = CLS_NONE;
        case (ltr)
            LTR_UC_M, LTR_UC_L, LTR_UC_C, LTR_UC_S, LTR_UC_Q, LTR_UC_T: cls = CLS_PAIR_ABS;
            LTR_LC_M, LTR_LC_L, LTR_LC_C, LTR_LC_S, LTR_LC_Q, LTR_LC_T: cls = CLS_PAIR_REL;
            LTR_UC_H: cls = CLS_H_ABS;
            LTR_LC_H: cls = CLS_H_REL;
            LTR_UC_V: cls = CLS_V_ABS;
            LTR_LC_V: cls = CLS_V_REL;
            LTR_UC_A: cls = CLS_ARC_ABS;
            LTR_LC_A: cls = CLS_ARC_REL;
            default:  cls = CLS_NONE;
        endcase
        return cls;
    endfunction

    // Clamp a 32-bit port value into the internal coordinate range
    function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(input logic signed [31:0] v);
        logic signed [64:0] w;
        logic signed [COORD_WIDTH-1:0] r;
        w = 65'(v);
        if (w > 65'(COORD_MAX)) begin
            r = COORD_MAX;
        end else if (w < 65'(COORD_MIN)) begin
            r = COORD_MIN;
        end else begin
            r = w[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

    // Saturating add in the internal coordinate range
    function automatic logic signed [COORD_WIDTH-1:0] sat_add(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        logic signed [COORD_WIDTH:0] s;
        logic signed [COORD_WIDTH-1:0] r;
        s = (COORD_WIDTH+1)'(a) + (COORD_WIDTH+1)'(b);
        if (s[COORD_WIDTH] != s[COORD_WIDTH-1]) begin
            r = s[COORD_WIDTH] ? COORD_MIN : COORD_MAX;
        end else begin
            r = s[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

    // Low 32 bits of a coordinate, sign extended first when the coordinate is narrower
    function automatic logic signed [31:0] to_port(input logic signed [COORD_WIDTH-1:0] x);
        logic signed [64:0] w;
        w = 65'(x);
        return w[31:0];
    endfunction

endpackage

>>> rtl/core/ppa_in_stage.sv
// Input register of the path point absolutizer: holds one accepted token.
// Depends on ppa_pkg for the token and slot types.
module ppa_in_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ppa_pkg::ppa_in_t s_data,
    input  logic             fire,
    output ppa_pkg::ppa_slot_t slot
);

    logic             vld_reg;
    logic             vld_next;
    ppa_pkg::ppa_in_t data_reg;
    logic             take;

    // Accept whenever the slot is empty or drains this cycle
    assign s_ready = !vld_reg || fire;
    assign take    = s_valid && s_ready;

    always_comb begin
        vld_next = vld_reg;
        if (take) begin
            vld_next = 1'b1;
        end else if (fire) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Capture the payload on each transfer
    always_ff @(posedge aclk) begin
        if (take) begin
            data_reg <= s_data;
        end
    end

    assign slot.valid = vld_reg;
    assign slot.data  = data_reg;

endmodule

>>> rtl/core/ppa_point_unit.sv
// Segment state and point arithmetic of the path point absolutizer.
// Depends on ppa_pkg for letter classes, saturating add and types.
module ppa_point_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  ppa_pkg::ppa_slot_t slot,
    input  logic               fire,
    output ppa_pkg::ppa_step_t step
);

    localparam int CW = ppa_pkg::COORD_WIDTH;

    logic [7:0]             segment_letter_reg, segment_letter_next;
    logic [2:0]             param_position_reg, param_position_next;
    logic signed [CW-1:0]   held_x_reg, held_x_next;
    logic signed [CW-1:0]   last_x_reg, last_x_next;
    logic signed [CW-1:0]   last_y_reg, last_y_next;
    logic signed [CW-1:0]   v;
    logic signed [CW-1:0]   px;
    logic signed [CW-1:0]   py;
    logic                   emit;
    ppa_pkg::letter_class_t cls;

    // Decode the token against the current segment
    always_comb begin
        segment_letter_next = segment_letter_reg;
        param_position_next = param_position_reg;
        held_x_next         = held_x_reg;
        emit                = 1'b0;
        px                  = last_x_reg;
        py                  = last_y_reg;
        v                   = ppa_pkg::clamp_coord(slot.data.value);
        cls                 = ppa_pkg::letter_class(segment_letter_reg);

        if (slot.data.command == ppa_pkg::CMD_LETTER) begin
            segment_letter_next = slot.data.path_letter;
            param_position_next = ppa_pkg::POS_START;
        end else begin
            case (cls)
                ppa_pkg::CLS_PAIR_ABS, ppa_pkg::CLS_PAIR_REL: begin
                    if (param_position_reg == ppa_pkg::POS_START) begin
                        held_x_next         = v;
                        param_position_next = ppa_pkg::POS_PAIR_Y;
                    end else begin
                        param_position_next = ppa_pkg::POS_START;
                        emit                = 1'b1;
                        if (cls == ppa_pkg::CLS_PAIR_REL) begin
                            px = ppa_pkg::sat_add(last_x_reg, held_x_reg);
                            py = ppa_pkg::sat_add(last_y_reg, v);
                        end else begin
                            px = held_x_reg;
                            py = v;
                        end
                    end
                end
                ppa_pkg::CLS_H_ABS: begin
                    emit = 1'b1;
                    px   = v;
                end
                ppa_pkg::CLS_H_REL: begin
                    emit = 1'b1;
                    px   = ppa_pkg::sat_add(last_x_reg, v);
                end
                ppa_pkg::CLS_V_ABS: begin
                    emit = 1'b1;
                    py   = v;
                end
                ppa_pkg::CLS_V_REL: begin
                    emit = 1'b1;
                    py   = ppa_pkg::sat_add(last_y_reg, v);
                end
                ppa_pkg::CLS_ARC_ABS, ppa_pkg::CLS_ARC_REL: begin
                    if (param_position_reg == ppa_pkg::POS_ARC_X) begin
                        held_x_next         = v;
                        param_position_next = ppa_pkg::POS_ARC_Y;
                    end else if (param_position_reg >= ppa_pkg::POS_ARC_Y) begin
                        param_position_next = ppa_pkg::POS_START;
                        emit                = 1'b1;
                        if (cls == ppa_pkg::CLS_ARC_REL) begin
                            px = ppa_pkg::sat_add(last_x_reg, held_x_reg);
                            py = ppa_pkg::sat_add(last_y_reg, v);
                        end else begin
                            px = held_x_reg;
                            py = v;
                        end
                    end else begin
                        // Skip radii, rotation and flags
                        param_position_next = param_position_reg + 3'd1;
                    end
                end
                default: begin
                end
            endcase
        end

        last_x_next = emit ? px : last_x_reg;
        last_y_next = emit ? py : last_y_reg;
    end

    // Advance the state once per token leaving the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            segment_letter_reg <= '0;
            param_position_reg <= ppa_pkg::POS_START;
            held_x_reg         <= '0;
            last_x_reg         <= '0;
            last_y_reg         <= '0;
        end else if (fire) begin
            segment_letter_reg <= segment_letter_next;
            param_position_reg <= param_position_next;
            held_x_reg         <= held_x_next;
            last_x_reg         <= last_x_next;
            last_y_reg         <= last_y_next;
        end
    end

    assign step.emit          = emit;
    assign step.point.point_x = ppa_pkg::to_port(px);
    assign step.point.point_y = ppa_pkg::to_port(py);

    // Position never runs past the arc's last parameter
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        param_position_reg <= ppa_pkg::POS_ARC_Y)
        else $error("param position out of range");

    // A letter token never produces a point
    a_letter_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        slot.valid && slot.data.command == ppa_pkg::CMD_LETTER |-> !emit)
        else $error("letter token emitted a point");

    // An emitted point becomes the reference for relative forms
    a_last_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && emit |=> last_x_reg == $past(px) && last_y_reg == $past(py))
        else $error("last point not updated after emit");

    // Letter tokens restart the pair or arc group
    a_letter_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && slot.data.command == ppa_pkg::CMD_LETTER |=>
        param_position_reg == ppa_pkg::POS_START)
        else $error("letter did not clear position");

endmodule

>>> rtl/core/ppa_out_stage.sv
// Result register of the path point absolutizer: holds one point for the receiver.
// Depends on ppa_pkg for the result and step types.
module ppa_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  ppa_pkg::ppa_step_t step,
    input  logic               fire,
    output logic               free,
    output logic               m_valid,
    input  logic               m_ready,
    output ppa_pkg::ppa_out_t  m_data
);

    logic              vld_reg;
    logic              vld_next;
    ppa_pkg::ppa_out_t data_reg;

    // Room for a new result when empty or when the held one transfers now
    assign free = !vld_reg || m_ready;

    always_comb begin
        vld_next = vld_reg;
        if (fire) begin
            vld_next = step.emit;
        end else if (m_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Load the point only when the token produced one
    always_ff @(posedge aclk) begin
        if (fire && step.emit) begin
            data_reg <= step.point;
        end
    end

    assign m_valid = vld_reg;
    assign m_data  = data_reg;

endmodule

>>> rtl/core/path_point_absolutizer.sv
// Path point absolutizer: turns path letter and parameter tokens into absolute points.
// Depends on ppa_pkg, ppa_in_stage, ppa_point_unit and ppa_out_stage.
//
// Usage:
//   s_valid / s_ready / s_data carry one token per transfer: a path letter
//   (command = 0) or one signed Q16.16 parameter (command = 1).
//   m_valid / m_ready / m_data carry one absolute point per transfer.
//   A token yields zero or one point; letters, unpaired values, skipped arc
//   parameters and tokens under Z or unknown letters yield none.
// Timing:
//   One token is taken per cycle while the result side has room. A token waits
//   in the input register, where the segment logic and one saturating add per axis
//   compute its point, which then loads into the result register and raises
//   m_valid.
// Reset (aresetn low, synchronous) empties both registers, clears the
//   segment letter and the position count, and sets the last point to 0,0.
// Stall: while m_ready is low with a point waiting, the input register still
//   takes one token and then holds it; tokens that yield no point pass
//   through only once the result register is free.
module path_point_absolutizer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ppa_pkg::ppa_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ppa_pkg::ppa_out_t m_data
);

    ppa_pkg::ppa_slot_t slot;
    ppa_pkg::ppa_step_t step;
    logic               free;
    logic               fire;

    // Move a token out of the input register when the result side has room
    assign fire = slot.valid && free;

    ppa_in_stage u_in_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .fire    (fire),
        .slot    (slot)
    );

    ppa_point_unit u_point_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .slot    (slot),
        .fire    (fire),
        .step    (step)
    );

    ppa_out_stage u_out_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .fire    (fire),
        .free    (free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> tb/sv/path_point_absolutizer_tb.sv
// Testbench for path_point_absolutizer: directed token table, then random path sequences.
// Depends on ppa_pkg and the path_point_absolutizer RTL; keeps its own point predictor.
// Every point transfer is compared field by field with the oldest predicted point.
`timescale 1ns / 100ps

module path_point_absolutizer_tb;

    localparam int          RANDOM_TOKENS = 1100;
    localparam int          LONG_HOLD     = 80;
    localparam int          DRAIN_LIMIT   = 5000;
    localparam int          SETTLE_CYCLES = 8;
    localparam logic [7:0]  LTR_UC_Z      = 8'h5A;

    // Letters grouped by how many parameters make one point
    localparam logic [11:0][7:0] PAIR_LETTERS = {
        ppa_pkg::LTR_UC_M, ppa_pkg::LTR_UC_L, ppa_pkg::LTR_UC_C, ppa_pkg::LTR_UC_S,
        ppa_pkg::LTR_UC_Q, ppa_pkg::LTR_UC_T, ppa_pkg::LTR_LC_M, ppa_pkg::LTR_LC_L,
        ppa_pkg::LTR_LC_C, ppa_pkg::LTR_LC_S, ppa_pkg::LTR_LC_Q, ppa_pkg::LTR_LC_T};
    localparam logic [3:0][7:0]  LINE_LETTERS = {ppa_pkg::LTR_UC_H, ppa_pkg::LTR_LC_H,
                                                 ppa_pkg::LTR_UC_V, ppa_pkg::LTR_LC_V};
    localparam logic [1:0][7:0]  ARC_LETTERS  = {ppa_pkg::LTR_UC_A, ppa_pkg::LTR_LC_A};

    typedef struct {
        ppa_pkg::ppa_in_t  tok;
        bit                typed;
        ppa_pkg::ppa_out_t pt;
    } stim_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    ppa_pkg::ppa_in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    ppa_pkg::ppa_out_t m_data;

    // Predictor state
    logic [7:0]         cur_letter;
    logic [2:0]         param_idx;
    logic signed [31:0] pending_x;
    logic signed [31:0] pen_x;
    logic signed [31:0] pen_y;

    ppa_pkg::ppa_out_t expected_points[$];
    stim_row_t         directed_rows[$];

    int idle_pct;
    bit long_hold_req;
    int mismatch_count;
    int points_checked;
    int tokens_sent;
    int sequences_sent;

    path_point_absolutizer u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4 aclk = ~aclk;

    // Add with clipping to the signed 32-bit coordinate range
    function automatic logic signed [31:0] sat_sum(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > longint'(ppa_pkg::COORD_MAX)) return ppa_pkg::COORD_MAX;
        if (s < longint'(ppa_pkg::COORD_MIN)) return ppa_pkg::COORD_MIN;
        return 32'(s);
    endfunction

    // Advance the predictor by one token; got is set when the token yields a point
    task automatic absolutize_token(input ppa_pkg::ppa_in_t tok, output bit got,
                                    output ppa_pkg::ppa_out_t pt);
        logic signed [31:0] v;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        bit                 rel;
        got = 1'b0;
        pt  = '0;
        nx  = pen_x;
        ny  = pen_y;
        // ASCII bit 5 marks the lowercase, relative form
        rel = cur_letter[5];
        if (tok.command == ppa_pkg::CMD_LETTER) begin
            cur_letter = tok.path_letter;
            param_idx  = ppa_pkg::POS_START;
        end else begin
            // Coordinates are 32 bits wide, so the input clamp never bites
            v = tok.value;
            case (cur_letter)
                ppa_pkg::LTR_UC_M, ppa_pkg::LTR_UC_L, ppa_pkg::LTR_UC_C,
                ppa_pkg::LTR_UC_S, ppa_pkg::LTR_UC_Q, ppa_pkg::LTR_UC_T,
                ppa_pkg::LTR_LC_M, ppa_pkg::LTR_LC_L, ppa_pkg::LTR_LC_C,
                ppa_pkg::LTR_LC_S, ppa_pkg::LTR_LC_Q, ppa_pkg::LTR_LC_T: begin
                    if (param_idx == ppa_pkg::POS_START) begin
                        pending_x = v;
                        param_idx = ppa_pkg::POS_PAIR_Y;
                    end else begin
                        param_idx = ppa_pkg::POS_START;
                        got       = 1'b1;
                        nx        = rel ? sat_sum(pen_x, pending_x) : pending_x;
                        ny        = rel ? sat_sum(pen_y, v) : v;
                    end
                end
                ppa_pkg::LTR_UC_H: begin
                    got = 1'b1;
                    nx  = v;
                end
                ppa_pkg::LTR_LC_H: begin
                    got = 1'b1;
                    nx  = sat_sum(pen_x, v);
                end
                ppa_pkg::LTR_UC_V: begin
                    got = 1'b1;
                    ny  = v;
                end
                ppa_pkg::LTR_LC_V: begin
                    got = 1'b1;
                    ny  = sat_sum(pen_y, v);
                end
                ppa_pkg::LTR_UC_A, ppa_pkg::LTR_LC_A: begin
                    // Only the end point of each seven-value group is emitted
                    if (param_idx == ppa_pkg::POS_ARC_X) begin
                        pending_x = v;
                        param_idx = ppa_pkg::POS_ARC_Y;
                    end else if (param_idx >= ppa_pkg::POS_ARC_Y) begin
                        param_idx = ppa_pkg::POS_START;
                        got       = 1'b1;
                        nx        = rel ? sat_sum(pen_x, pending_x) : pending_x;
                        ny        = rel ? sat_sum(pen_y, v) : v;
                    end else begin
                        param_idx = param_idx + 3'd1;
                    end
                end
                default: ;
            endcase
        end
        if (got) begin
            pen_x      = nx;
            pen_y      = ny;
            pt.point_x = nx;
            pt.point_y = ny;
        end
    endtask

    // Offer one token, wait for its transfer, then record what it should produce
    task automatic send_token(input ppa_pkg::ppa_in_t tok, input bit typed,
                              input ppa_pkg::ppa_out_t typed_pt);
        bit                got;
        ppa_pkg::ppa_out_t pt;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= tok;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        absolutize_token(tok, got, pt);
        if (typed) expected_points = {expected_points, typed_pt};
        else if (got) expected_points = {expected_points, pt};
        tokens_sent++;
    endtask

    function automatic ppa_pkg::ppa_in_t letter_token(input logic [7:0] ltr);
        ppa_pkg::ppa_in_t t;
        t.command     = ppa_pkg::CMD_LETTER;
        t.path_letter = ltr;
        t.value       = $urandom;
        return t;
    endfunction

    function automatic ppa_pkg::ppa_in_t param_token(input logic [31:0] v);
        ppa_pkg::ppa_in_t t;
        t.command     = ppa_pkg::CMD_PARAM;
        t.path_letter = 8'($urandom_range(0, 255));
        t.value       = v;
        return t;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return ppa_pkg::COORD_MAX;
            1:       return ppa_pkg::COORD_MIN;
            2, 3:    return $urandom;
            4:       return $urandom_range(0, 2) - 1;
            // Typical drawing coordinates, within +-2048.0
            default: return $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
        endcase
    endfunction

    task automatic table_letter(input logic [7:0] ltr);
        stim_row_t r;
        r.tok   = letter_token(ltr);
        r.typed = 1'b0;
        r.pt    = '0;
        directed_rows = {directed_rows, r};
    endtask

    task automatic table_param(input logic [31:0] v);
        stim_row_t r;
        r.tok   = param_token(v);
        r.typed = 1'b0;
        r.pt    = '0;
        directed_rows = {directed_rows, r};
    endtask

    task automatic table_point(input logic [31:0] v, input logic [31:0] x, input logic [31:0] y);
        stim_row_t r;
        r.tok        = param_token(v);
        r.typed      = 1'b1;
        r.pt.point_x = x;
        r.pt.point_y = y;
        directed_rows = {directed_rows, r};
    endtask

    // One letter followed by its parameters; mostly well formed, sometimes broken or noise
    task automatic send_random_sequence();
        logic [7:0]        ltr;
        int                group;
        int                n;
        int                kind;
        ppa_pkg::ppa_out_t none;
        none = '0;
        kind = $urandom_range(0, 19);
        if (kind < 16) begin
            case ($urandom_range(0, 3))
                0, 1: begin
                    ltr   = PAIR_LETTERS[$urandom_range(0, 11)];
                    group = 2;
                end
                2: begin
                    ltr   = LINE_LETTERS[$urandom_range(0, 3)];
                    group = 1;
                end
                default: begin
                    ltr   = ARC_LETTERS[$urandom_range(0, 1)];
                    group = 7;
                end
            endcase
            n = group * $urandom_range(1, 4);
            // Broken sequence: one value short or one too many
            if (kind >= 14) n = (kind == 14) ? n - 1 : n + 1;
        end else begin
            ltr = (kind == 16) ? LTR_UC_Z : 8'($urandom_range(0, 255));
            n   = $urandom_range(0, 4);
        end
        send_token(letter_token(ltr), 1'b0, none);
        repeat (n) send_token(param_token(rand_value()), 1'b0, none);
        sequences_sent++;
    endtask

    // Result side: random stall bursts, one long hold on request, compare each transfer
    initial begin : point_sink
        int                hold_cycles;
        ppa_pkg::ppa_out_t want;
        hold_cycles = 0;
        m_ready     = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                hold_cycles   = LONG_HOLD;
                long_hold_req = 1'b0;
            end else if (hold_cycles == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                hold_cycles = $urandom_range(1, 14);
            end
            if (hold_cycles != 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else begin
                m_ready <= 1'b1;
            end
            @(negedge aclk);
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    $error("unexpected point: point_x=%h point_y=%h",
                           m_data.point_x, m_data.point_y);
                    mismatch_count++;
                end else begin
                    want = expected_points.pop_front();
                    if (m_data.point_x !== want.point_x) begin
                        $error("point_x: expected %h, actual %h", want.point_x, m_data.point_x);
                        mismatch_count++;
                    end
                    if (m_data.point_y !== want.point_y) begin
                        $error("point_y: expected %h, actual %h", want.point_y, m_data.point_y);
                        mismatch_count++;
                    end
                end
                points_checked++;
            end
            @(posedge aclk);
        end
    end

    // Hard stop for a hung run
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : token_source
        int drain_wait;
        int target;
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        idle_pct       = 0;
        long_hold_req  = 1'b0;
        mismatch_count = 0;
        points_checked = 0;
        tokens_sent    = 0;
        sequences_sent = 0;
        cur_letter     = 8'h00;
        param_idx      = ppa_pkg::POS_START;
        pending_x      = '0;
        pen_x          = '0;
        pen_y          = '0;

        // Parameter before any letter: ignored
        table_param(32'h7FFF_FFFF);
        // Relative pair before any point: taken from 0,0
        table_letter(ppa_pkg::LTR_LC_M);
        table_param(32'h0001_0000);
        table_point(32'h0002_0000, 32'h0001_0000, 32'h0002_0000);
        // Absolute extremes
        table_letter(ppa_pkg::LTR_UC_M);
        table_param(32'h7FFF_FFFF);
        table_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        // Relative step past both extremes saturates
        table_letter(ppa_pkg::LTR_LC_L);
        table_param(32'h0000_0001);
        table_point(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        // Unpaired x dropped by a new letter; Z ignores its values
        table_letter(ppa_pkg::LTR_UC_L);
        table_param(32'h0005_0000);
        table_letter(LTR_UC_Z);
        table_param(32'h0003_0000);
        // Horizontal keeps y, relative vertical saturates low
        table_letter(ppa_pkg::LTR_UC_H);
        table_point(32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
        table_letter(ppa_pkg::LTR_LC_V);
        table_point(32'h8000_0000, 32'h0000_0000, 32'h8000_0000);
        // Relative arc: five skipped values, then the end point
        table_letter(ppa_pkg::LTR_LC_A);
        table_param(32'h7FFF_FFFF);
        table_param(32'h8000_0000);
        table_param(32'h0000_0000);
        table_param(32'hFFFF_FFFF);
        table_param(32'h0001_0000);
        table_param(32'h0000_8000);
        table_point(32'hFFFF_0000, 32'h0000_8000, 32'h8000_0000);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table
        idle_pct = 10;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].typed) begin
                send_token(directed_rows[i].tok, 1'b1, directed_rows[i].pt);
            end else begin
                send_token(directed_rows[i].tok, 1'b0, directed_rows[i].pt);
            end
        end

        // Random: start with a long output hold while tokens keep coming
        target        = tokens_sent;
        long_hold_req = 1'b1;
        while (tokens_sent < target + 350) send_random_sequence();
        idle_pct = 35;
        while (tokens_sent < target + 650) send_random_sequence();

        // Pause until every predicted point has arrived
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_points.size() != 0);

        // Last stretch runs at full rate on both sides
        idle_pct = 0;
        while (tokens_sent < target + RANDOM_TOKENS) send_random_sequence();
        s_valid <= 1'b0;

        drain_wait = 0;
        while (expected_points.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_points.size() != 0) begin
            $error("%0d predicted points never arrived", expected_points.size());
            mismatch_count += expected_points.size();
        end

        $display("Run: %0d tokens (%0d table rows, %0d random sequences), %0d points compared",
                 tokens_sent, directed_rows.size(), sequences_sent, points_checked);
        $display("Run: pair, line and arc letters, saturation, dropped values, stall and drain");
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/ppa_pkg.sv
rtl/core/ppa_in_stage.sv
rtl/core/ppa_point_unit.sv
rtl/core/ppa_out_stage.sv
rtl/core/path_point_absolutizer.sv
tb/sv/path_point_absolutizer_tb.sv
